// ===== rtl/srb_pkg.sv =====
package srb_pkg;

    // Result status codes carried on tuser
    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_RELEASED = 2'd0,
        ST_STALE    = 2'd1,
        ST_BEYOND   = 2'd2
    } srb_status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASS,
        S_DROP,
        S_SCAN,
        S_EMIT
    } srb_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic in_ready;   // input channel may take a transfer
        logic store;      // write held block into its slot
        logic emit_drop;  // load a drop result into the output register
        logic emit_rel;   // load a release result, clear slot, advance
    } srb_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic in_fire;    // input transfer this cycle
        logic drop;       // held block cannot be kept
        logic head_valid; // slot of the expected number holds a block
        logic out_free;   // output register can take a result
    } srb_sts_t;

endpackage

// ===== rtl/srb_ram.sv =====
module srb_ram #(
    parameter int WIDTH = 44,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/srb_ctrl.sv =====
module srb_ctrl
    import srb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  srb_sts_t sts,
    output srb_cmd_t cmd
);

    srb_state_t state_reg;
    srb_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                cmd.in_ready = 1'b1;
                if (sts.in_fire) begin
                    state_next = S_CLASS;
                end
            end
            S_CLASS: begin
                if (sts.drop) begin
                    state_next = S_DROP;
                end else begin
                    cmd.store  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_DROP: begin
                if (sts.out_free) begin
                    cmd.emit_drop = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            // read slot of expected number; data is ready next cycle
            S_SCAN: begin
                if (sts.head_valid) begin
                    state_next = S_EMIT;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit_rel = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/srb_dp.sv =====
module srb_dp
    import srb_pkg::*;
#(
    parameter int WINDOW       = 16,
    parameter int SEQ_BITS     = 16,
    parameter int LEN_BITS     = 12,
    parameter int PAYLOAD_BITS = 32,
    parameter int DATA_W       = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  srb_cmd_t            cmd,
    output srb_sts_t            sts,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [DATA_W-1:0]   s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [DATA_W-1:0]   m_tdata,
    output logic [STATUS_W-1:0] m_tuser,
    output logic                m_tlast
);

    localparam int IDX_W  = $clog2(WINDOW);
    localparam int SLOT_W = LEN_BITS + PAYLOAD_BITS;
    localparam int FLD_W  = SEQ_BITS + SLOT_W;
    localparam logic [IDX_W:0]      WIN_EXT = (IDX_W + 1)'(WINDOW);
    localparam logic [IDX_W-1:0]    IDX_TOP = IDX_W'(WINDOW - 1);
    localparam logic [SEQ_BITS-1:0] WIN_SEQ = SEQ_BITS'(WINDOW);

    // Held input block
    logic [SEQ_BITS-1:0]     seq_reg;
    logic [LEN_BITS-1:0]     len_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;

    // Window state
    logic [SEQ_BITS-1:0] ne_reg;
    logic [SEQ_BITS-1:0] ne_next;
    logic [IDX_W-1:0]    head_reg;
    logic [IDX_W-1:0]    head_next;
    logic [WINDOW-1:0]   valid_reg;

    // Output register
    logic                    ovalid_reg;
    logic [SEQ_BITS-1:0]     oseq_reg;
    logic [LEN_BITS-1:0]     olen_reg;
    logic [PAYLOAD_BITS-1:0] opay_reg;
    logic [STATUS_W-1:0]     ostat_reg;
    logic                    olast_reg;

    logic [SEQ_BITS-1:0] seq_off;
    logic                behind;
    logic                beyond;
    logic [IDX_W:0]      idx_sum;
    logic [IDX_W-1:0]    idx;
    logic                dup;
    logic                in_fire;
    logic                out_free;
    logic [SLOT_W-1:0]   rd_data;

    assign in_fire  = s_tvalid && cmd.in_ready;
    assign s_tready = cmd.in_ready;
    assign out_free = !ovalid_reg || m_tready;

    // Capture the input transfer
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            seq_reg <= s_tdata[SEQ_BITS-1:0];
            len_reg <= s_tdata[SEQ_BITS +: LEN_BITS];
            pay_reg <= s_tdata[SEQ_BITS + LEN_BITS +: PAYLOAD_BITS];
        end
    end

    // Classify: offset from expected number and slot of the block
    assign seq_off = seq_reg - ne_reg;
    assign behind  = seq_off[SEQ_BITS-1];
    assign beyond  = !behind && (seq_off >= WIN_SEQ);
    assign idx_sum = {1'b0, head_reg} + {1'b0, seq_off[IDX_W-1:0]};
    always_comb begin
        // number wrapped past zero: the block's number is below WINDOW
        if (seq_reg < ne_reg) begin
            idx = seq_reg[IDX_W-1:0];
        end else if (idx_sum >= WIN_EXT) begin
            idx = IDX_W'(idx_sum - WIN_EXT);
        end else begin
            idx = idx_sum[IDX_W-1:0];
        end
    end
    assign dup = valid_reg[idx];

    // Expected number and its slot after one release
    assign ne_next = ne_reg + 1'b1;
    always_comb begin
        if (&ne_reg || head_reg == IDX_TOP) begin
            head_next = '0;
        end else begin
            head_next = head_reg + 1'b1;
        end
    end

    // Slot storage
    srb_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(WINDOW)
    ) u_ram (
        .clk  (aclk),
        .we   (cmd.store),
        .waddr(idx),
        .wdata({pay_reg, len_reg}),
        .raddr(head_reg),
        .rdata(rd_data)
    );

    // Window control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ne_reg    <= '0;
            head_reg  <= '0;
            valid_reg <= '0;
        end else if (cmd.store) begin
            valid_reg[idx] <= 1'b1;
        end else if (cmd.emit_rel) begin
            valid_reg[head_reg] <= 1'b0;
            ne_reg              <= ne_next;
            head_reg            <= head_next;
        end
    end

    // Output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (cmd.emit_drop || cmd.emit_rel) begin
            ovalid_reg <= 1'b1;
        end else if (m_tready) begin
            ovalid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if (cmd.emit_drop) begin
            oseq_reg  <= seq_reg;
            olen_reg  <= '0;
            opay_reg  <= pay_reg;
            ostat_reg <= beyond ? ST_BEYOND : ST_STALE;
            olast_reg <= 1'b1;
        end else if (cmd.emit_rel) begin
            oseq_reg  <= ne_reg;
            olen_reg  <= rd_data[LEN_BITS-1:0];
            opay_reg  <= rd_data[LEN_BITS +: PAYLOAD_BITS];
            ostat_reg <= ST_RELEASED;
            olast_reg <= !valid_reg[head_next];
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {{(DATA_W - FLD_W){1'b0}}, opay_reg, olen_reg, oseq_reg};
    assign m_tuser  = ostat_reg;
    assign m_tlast  = olast_reg;

    assign sts.in_fire    = in_fire;
    assign sts.drop       = behind || beyond || dup;
    assign sts.head_valid = valid_reg[head_reg];
    assign sts.out_free   = out_free;

endmodule

// ===== rtl/sequence_reorder_buffer_core.sv =====
// Resequencer for blocks that arrive out of order.
// Input channel s_*: one transfer per block (sequence number, length, handle).
// Output channel m_*: released blocks in sequence order, status on tuser,
// tlast on the final result caused by one input block. A block that is
// stale, a duplicate or beyond the window gives a single drop result with
// length zero and tlast set; the window is then left unchanged.
// Blocks within WINDOW of the expected number are parked in slot memory.
// A drop result passes the classify and drop states before it is registered
// at the output; the first release of a stored block passes classify, slot
// scan and emit. An input block goes through accept, classify, then drop or
// slot scan, plus a scan and an emit per released block, set by the registered
// slot memory read before each release; s_tready is high only in the accept cycle.
// Reset (aresetn low, synchronous) clears all slots and sets the expected
// number to zero; no clearing pass is needed.
// One output register parts the channels: while m_tready is low a pending
// result holds, and the block waits at its next result but can still take
// the next input transfer when it has no result to place.
module sequence_reorder_buffer_core
    import srb_pkg::*;
#(
    parameter int WINDOW       = 16,
    parameter int SEQ_BITS     = 16,
    parameter int LEN_BITS     = 12,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    // seq_number, block_length, payload (from bit 0 up)
    input  logic [((SEQ_BITS + LEN_BITS + PAYLOAD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // out_seq, out_length, out_payload (from bit 0 up)
    output logic [((SEQ_BITS + LEN_BITS + PAYLOAD_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // status
    output logic [STATUS_W-1:0] m_tuser,
    output logic                m_tlast,
    output logic                m_tvalid,
    input  logic                m_tready
);

    localparam int DATA_W = ((SEQ_BITS + LEN_BITS + PAYLOAD_BITS + 7) / 8) * 8;

    srb_cmd_t cmd;
    srb_sts_t sts;

    srb_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .sts    (sts),
        .cmd    (cmd)
    );

    srb_dp #(
        .WINDOW      (WINDOW),
        .SEQ_BITS    (SEQ_BITS),
        .LEN_BITS    (LEN_BITS),
        .PAYLOAD_BITS(PAYLOAD_BITS),
        .DATA_W      (DATA_W)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

// ===== sim/srb_checker.sv =====
// Watches both channels of the resequencer, predicts each result and checks it.
module srb_checker
    import srb_pkg::*;
#(
    parameter int WINDOW       = 16,
    parameter int SEQ_BITS     = 16,
    parameter int LEN_BITS     = 12,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    // seq_number, block_length, payload (from bit 0 up)
    input  logic [((SEQ_BITS + LEN_BITS + PAYLOAD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    input  logic                s_tvalid,
    input  logic                s_tready,
    // out_seq, out_length, out_payload (from bit 0 up)
    input  logic [((SEQ_BITS + LEN_BITS + PAYLOAD_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // status
    input  logic [STATUS_W-1:0] m_tuser,
    input  logic                m_tlast,
    input  logic                m_tvalid,
    input  logic                m_tready,
    output int                  errors,
    output int                  outstanding
);

    typedef struct {
        logic [SEQ_BITS-1:0]     seq;
        logic [LEN_BITS-1:0]     len;
        logic [PAYLOAD_BITS-1:0] pay;
        srb_status_t             status;
        logic                    last;
    } block_result_t;

    // Predicted results, oldest first
    block_result_t due_blocks[$];
    block_result_t want;

    // Shadow copy of the window
    logic [SEQ_BITS-1:0]     next_seq;
    logic                    slot_full [WINDOW];
    logic [LEN_BITS-1:0]     slot_len  [WINDOW];
    logic [PAYLOAD_BITS-1:0] slot_pay  [WINDOW];

    int fail_count = 0;

    logic [SEQ_BITS-1:0]     got_seq;
    logic [LEN_BITS-1:0]     got_len;
    logic [PAYLOAD_BITS-1:0] got_pay;

    assign got_seq = m_tdata[SEQ_BITS-1:0];
    assign got_len = m_tdata[SEQ_BITS +: LEN_BITS];
    assign got_pay = m_tdata[SEQ_BITS + LEN_BITS +: PAYLOAD_BITS];

    task automatic push_result(input logic [SEQ_BITS-1:0] seq,
                               input logic [LEN_BITS-1:0] len,
                               input logic [PAYLOAD_BITS-1:0] pay,
                               input srb_status_t status,
                               input logic last);
        block_result_t r;
        r.seq    = seq;
        r.len    = len;
        r.pay    = pay;
        r.status = status;
        r.last   = last;
        due_blocks.push_back(r);
    endtask

    // One arriving block: drop it, or park it and drain everything now in order
    task automatic resequence(input logic [SEQ_BITS-1:0] seq,
                              input logic [LEN_BITS-1:0] len,
                              input logic [PAYLOAD_BITS-1:0] pay);
        logic [SEQ_BITS-1:0] seq_off;
        int slot;
        int head;
        int released;
        seq_off = seq - next_seq;
        slot = int'(seq % WINDOW);
        if (seq_off[SEQ_BITS-1]) begin
            // behind the expected number
            push_result(seq, '0, pay, ST_STALE, 1'b1);
        end else if (seq_off >= WINDOW) begin
            push_result(seq, '0, pay, ST_BEYOND, 1'b1);
        end else if (slot_full[slot]) begin
            // duplicate, reported like a stale block
            push_result(seq, '0, pay, ST_STALE, 1'b1);
        end else begin
            slot_full[slot] = 1'b1;
            slot_len[slot]  = len;
            slot_pay[slot]  = pay;
            released = 0;
            head = int'(next_seq % WINDOW);
            while (released < WINDOW && slot_full[head]) begin
                push_result(next_seq, slot_len[head], slot_pay[head], ST_RELEASED, 1'b0);
                slot_full[head] = 1'b0;
                next_seq = next_seq + 1'b1;
                released++;
                head = int'(next_seq % WINDOW);
            end
            if (released > 0) begin
                due_blocks[due_blocks.size() - 1].last = 1'b1;
            end
        end
    endtask

    // Check output transfers, then predict from input transfers
    always @(posedge aclk) begin
        if (!aresetn) begin
            next_seq = '0;
            for (int i = 0; i < WINDOW; i++) begin
                slot_full[i] = 1'b0;
            end
            due_blocks.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_blocks.size() == 0) begin
                    $display("%0t: unexpected result seq %h len %h pay %h st %0d last %b",
                             $time, got_seq, got_len, got_pay, m_tuser, m_tlast);
                    fail_count++;
                end else begin
                    want = due_blocks.pop_front();
                    if (got_seq !== want.seq || got_len !== want.len ||
                        got_pay !== want.pay || m_tuser !== want.status ||
                        m_tlast !== want.last) begin
                        $display("%0t: result mismatch: expected seq %h len %h pay %h st %0d last %b",
                                 $time, want.seq, want.len, want.pay, want.status, want.last);
                        $display("%0t:                  actual   seq %h len %h pay %h st %0d last %b",
                                 $time, got_seq, got_len, got_pay, m_tuser, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                resequence(s_tdata[SEQ_BITS-1:0], s_tdata[SEQ_BITS +: LEN_BITS],
                           s_tdata[SEQ_BITS + LEN_BITS +: PAYLOAD_BITS]);
            end
        end
        errors      <= fail_count;
        outstanding <= due_blocks.size();
    end

endmodule

// ===== sim/sequence_reorder_buffer_core_tb.sv =====
module sequence_reorder_buffer_core_tb
    import srb_pkg::*;
();

    localparam int WINDOW       = 16;
    localparam int SEQ_BITS     = 16;
    localparam int LEN_BITS     = 12;
    localparam int PAYLOAD_BITS = 32;
    localparam int FIELDS_W     = SEQ_BITS + LEN_BITS + PAYLOAD_BITS;
    localparam int TD_W         = ((FIELDS_W + 7) / 8) * 8;

    localparam int HOLD_CYCLES = 200;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 20;

    typedef enum int {
        NZ_DUP,
        NZ_STALE,
        NZ_BEYOND,
        NZ_WILD
    } noise_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic [TD_W-1:0]     s_tdata  = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TD_W-1:0]     m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    logic                m_tlast;
    logic                m_tvalid;
    logic                m_tready = 1'b0;

    // steady: no idling on either side; hold_go: one long receiver hold-off
    logic steady  = 1'b0;
    logic hold_go = 1'b0;

    int errors;
    int outstanding;
    int blocks_sent = 0;
    int dead_cycles = 0;
    int hold_left   = 0;
    logic hold_taken = 1'b0;

    logic [SEQ_BITS-1:0] base;
    int phase_end;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    sequence_reorder_buffer_core #(
        .WINDOW      (WINDOW),
        .SEQ_BITS    (SEQ_BITS),
        .LEN_BITS    (LEN_BITS),
        .PAYLOAD_BITS(PAYLOAD_BITS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    srb_checker #(
        .WINDOW      (WINDOW),
        .SEQ_BITS    (SEQ_BITS),
        .LEN_BITS    (LEN_BITS),
        .PAYLOAD_BITS(PAYLOAD_BITS)
    ) checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .errors     (errors),
        .outstanding(outstanding)
    );

    // Receiver: random back-pressure, plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (steady) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= 15);
        end
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            dead_cycles <= 0;
        end else begin
            dead_cycles <= dead_cycles + 1;
        end
        if (dead_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, dead_cycles);
            $display("sequence_reorder_buffer_core_tb NOT OK");
            $finish;
        end
    end

    // One input transfer; called and returning at a falling edge
    task automatic send_block(input logic [SEQ_BITS-1:0] seq,
                              input logic [LEN_BITS-1:0] len,
                              input logic [PAYLOAD_BITS-1:0] pay);
        while (!steady && $urandom_range(0, 99) < 15) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= {{(TD_W - FIELDS_W){1'b0}}, pay, len, seq};
        s_tvalid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        blocks_sent++;
        @(negedge aclk);
    endtask

    // A run of consecutive numbers from base in shuffled order, with some noise mixed in
    task automatic send_group(input int k);
        int order [WINDOW];
        int pick;
        int tmp;
        noise_t kind;
        logic [SEQ_BITS-1:0] seq;
        for (int i = 0; i < k; i++) begin
            order[i] = i;
        end
        for (int i = k - 1; i > 0; i--) begin
            pick = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[pick];
            order[pick] = tmp;
        end
        for (int j = 0; j < k; j++) begin
            if ($urandom_range(0, 99) < 20) begin
                kind = noise_t'($urandom_range(0, 3));
                case (kind)
                    NZ_DUP: begin
                        if (j > 0) begin
                            seq = base + SEQ_BITS'(order[$urandom_range(0, j - 1)]);
                        end else begin
                            seq = base - 1'b1;
                        end
                    end
                    NZ_STALE: seq = base - SEQ_BITS'(1 + $urandom_range(0, 32000));
                    NZ_BEYOND: seq = base + SEQ_BITS'(k + WINDOW + $urandom_range(0, 30000));
                    default: seq = SEQ_BITS'($urandom);
                endcase
                send_block(seq, LEN_BITS'($urandom_range(0, 4095)), $urandom);
            end
            send_block(base + SEQ_BITS'(order[j]), LEN_BITS'($urandom_range(0, 4095)),
                       $urandom);
        end
        base = base + SEQ_BITS'(k);
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: in-order release, window edges, duplicate, stale, full drain
        send_block(16'd0, 12'd0, 32'h0000_0000);
        send_block(16'd16, 12'hFFF, 32'hFFFF_FFFF);   // last slot of the window, parked
        send_block(16'd17, 12'h5A5, 32'hA5A5_A5A5);   // first number past the window
        send_block(16'd16, 12'h123, 32'h1234_5678);   // duplicate of a parked block
        send_block(16'd0, 12'hABC, 32'hDEAD_BEEF);    // already released
        send_block(16'd32768, 12'hFFF, 32'h5555_5555); // farthest ahead
        send_block(16'd32769, 12'h000, 32'hAAAA_AAAA); // first number classed as behind
        for (int s = 15; s >= 1; s--) begin
            // last one fills the hole and releases a full window
            send_block(SEQ_BITS'(s), LEN_BITS'($urandom_range(0, 4095)), $urandom);
        end
        base = 16'd17;

        // Long hold-off on the receiver while a reversed window is offered
        hold_go <= 1'b1;
        for (int s = WINDOW - 1; s >= 0; s--) begin
            send_block(base + SEQ_BITS'(s), LEN_BITS'($urandom_range(0, 4095)), $urandom);
        end
        base = base + SEQ_BITS'(WINDOW);

        // Random groups, with a stretch of no idling in the middle
        while (blocks_sent < 160) begin
            steady <= (blocks_sent >= 90 && blocks_sent < 125);
            send_group($urandom_range(1, WINDOW));
        end

        // More random groups with idling on both sides
        steady <= 1'b0;
        phase_end = blocks_sent + 90;
        while (blocks_sent < phase_end) begin
            send_group($urandom_range(1, WINDOW));
        end
        s_tvalid <= 1'b0;

        while (outstanding != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (errors == 0 && outstanding == 0) begin
            $display("sequence_reorder_buffer_core_tb OK");
        end else begin
            $display("sequence_reorder_buffer_core_tb NOT OK");
        end
        $finish;
    end

endmodule
